FILE: rtl/tvt_pkg.sv
// Shared types, widths, constants and the fixed NTC curve for the thermistor converter.
// No dependencies; every other file refers to it by scoped names.
package tvt_pkg;

    // Field and register widths
    localparam int VOLT_W     = 12;
    localparam int TEMP_W     = 18;
    localparam int DIV_OHMS_W = 20;
    localparam int SUPPLY_W   = 13;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY  = 1'b1;

    localparam logic [DIV_OHMS_W-1:0] DIVIDER_RESET = 20'd12000;
    localparam logic [SUPPLY_W-1:0]   SUPPLY_RESET  = 13'd3300;

    // Curve storage
    localparam int CURVE_LEN = 49;
    localparam int CEL_W     = 8;
    localparam int OHMS_W    = 19;

    // Serial multiplier: radix-4, multiplier operand consumed two bits a cycle
    localparam int MUL_A_W   = 20;
    localparam int MUL_B_W   = 20;
    localparam int MUL_HI_W  = MUL_A_W + 2;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W / 2;
    localparam int MUL_CNT_W = 4;

    // Serial divider: restoring, two quotient bits a cycle
    localparam int DIV_N_W   = 38;
    localparam int DIV_D_W   = 19;
    localparam int DIV_STEPS = DIV_N_W / 2;
    localparam int DIV_CNT_W = 5;

    // Resistance width (divider quotient)
    localparam int R_W = DIV_N_W;

    localparam logic signed [TEMP_W-1:0] MILLI    = 18'sd1000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sh1ffff;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 18'sh20000;

    typedef struct packed {
        logic signed [CEL_W-1:0] celsius;
        logic [OHMS_W-1:0]       ohms;
    } curve_pt_t;

    // Search outcome: the two picked entries, same set when no interpolation
    typedef struct packed {
        logic      same;
        curve_pt_t lo;
        curve_pt_t hi;
    } search_res_t;

    // Fixed curve in listed order (the -25 C entry is out of order on purpose)
    function automatic curve_pt_t curve_entry(input logic [7:0] idx);
        curve_pt_t p;
        case (idx)
            8'd0:  p = '{-8'sd40, 19'd364600};
            8'd1:  p = '{-8'sd35, 19'd259800};
            8'd2:  p = '{-8'sd30, 19'd187440};
            8'd3:  p = '{-8'sd25, 19'd297060};
            8'd4:  p = '{-8'sd20, 19'd136830};
            8'd5:  p = '{-8'sd15, 19'd75370};
            8'd6:  p = '{-8'sd10, 19'd56800};
            8'd7:  p = '{-8'sd5,  19'd43220};
            8'd8:  p = '{8'sd0,   19'd33180};
            8'd9:  p = '{8'sd5,   19'd25700};
            8'd10: p = '{8'sd10,  19'd20070};
            8'd11: p = '{8'sd15,  19'd15790};
            8'd12: p = '{8'sd20,  19'd12520};
            8'd13: p = '{8'sd25,  19'd10000};
            8'd14: p = '{8'sd30,  19'd8040};
            8'd15: p = '{8'sd35,  19'd6510};
            8'd16: p = '{8'sd40,  19'd5300};
            8'd17: p = '{8'sd45,  19'd4340};
            8'd18: p = '{8'sd50,  19'd3580};
            8'd19: p = '{8'sd55,  19'd2960};
            8'd20: p = '{8'sd60,  19'd2470};
            8'd21: p = '{8'sd62,  19'd2300};
            8'd22: p = '{8'sd65,  19'd2070};
            8'd23: p = '{8'sd68,  19'd1860};
            8'd24: p = '{8'sd70,  19'd1740};
            8'd25: p = '{8'sd72,  19'd1620};
            8'd26: p = '{8'sd75,  19'd1470};
            8'd27: p = '{8'sd77,  19'd1370};
            8'd28: p = '{8'sd79,  19'd1290};
            8'd29: p = '{8'sd80,  19'd1250};
            8'd30: p = '{8'sd82,  19'd1170};
            8'd31: p = '{8'sd85,  19'd1060};
            8'd32: p = '{8'sd88,  19'd970};
            8'd33: p = '{8'sd90,  19'd910};
            8'd34: p = '{8'sd92,  19'd850};
            8'd35: p = '{8'sd95,  19'd780};
            8'd36: p = '{8'sd98,  19'd710};
            8'd37: p = '{8'sd100, 19'd670};
            8'd38: p = '{8'sd101, 19'd650};
            8'd39: p = '{8'sd102, 19'd640};
            8'd40: p = '{8'sd105, 19'd580};
            8'd41: p = '{8'sd108, 19'd540};
            8'd42: p = '{8'sd110, 19'd510};
            8'd43: p = '{8'sd113, 19'd470};
            8'd44: p = '{8'sd115, 19'd440};
            8'd45: p = '{8'sd118, 19'd410};
            8'd46: p = '{8'sd120, 19'd390};
            8'd47: p = '{8'sd123, 19'd360};
            default: p = '{8'sd125, 19'd340};
        endcase
        return p;
    endfunction

    localparam curve_pt_t FIRST_PT = curve_entry(8'd0);

    // Celsius to millidegrees
    function automatic logic signed [TEMP_W-1:0] to_millic(input logic signed [CEL_W-1:0] c);
        logic signed [TEMP_W-1:0] w;
        w = TEMP_W'(c);
        return w * MILLI;
    endfunction

endpackage

FILE: rtl/tvt_if.sv
// Valid/ready stream interfaces for the thermistor converter's input and result words.
// Depends on tvt_pkg for the field widths.
interface tvt_in_if;
    logic                         valid;
    logic                         ready;
    logic [tvt_pkg::VOLT_W-1:0]   voltage_mv;

    modport source (output valid, output voltage_mv, input ready);
    modport sink   (input valid, input voltage_mv, output ready);
endinterface

interface tvt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tvt_pkg::TEMP_W-1:0]  temp_millic;
    logic                               fault;

    modport source (output valid, output temp_millic, output fault, input ready);
    modport sink   (input valid, input temp_millic, input fault, output ready);
endinterface

FILE: rtl/thermistor_voltage_to_temperature.sv
// Thermistor divider voltage to temperature converter, top level.
// Depends on tvt_pkg, tvt_if, tvt_serial_mul, tvt_serial_div and tvt_search.
//
// Usage:
//   in_ch carries one word, voltage_mv, the divider midpoint in millivolts.
//   out_ch returns one word per input: temp_millic (signed, 1/1000 C) and fault.
//   cfg_we/cfg_index/cfg_data write divider_ohms (index 0) or supply_mv (index 1);
//   write them only while no conversion is in flight.
// Timing:
//   One word is in flight at a time; in_ch.ready is high while the converter is idle.
//   A fault word (zero volts or above supply) goes straight to the output state with
//   no arithmetic; the next word is taken once the result has moved into the output
//   register. The multiplier and divider run once at a clamp or an exact curve point
//   and twice when interpolating; the search settles a curve-end clamp in its check
//   state and otherwise runs its binary-search loop.
// Reset:
//   rst_n clears control state and loads divider_ohms=12000, supply_mv=3300.
// Stall:
//   The result sits in an output register; the next word may be accepted while it
//   waits. A finished result waits in its own state until the register frees up.
module thermistor_voltage_to_temperature #(
    parameter int TABLE_ENTRIES = 49
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tvt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvt_pkg::CFG_DATA_W-1:0]     cfg_data,
    tvt_in_if.sink                             in_ch,
    tvt_out_if.source                          out_ch
);

    localparam int TEMP_W = tvt_pkg::TEMP_W;
    localparam int SUM_W  = tvt_pkg::DIV_N_W + 2;
    localparam int DCM_W  = 19;
    localparam logic signed [DCM_W-1:0] DC_MILLI = 19'sd1000;
    localparam logic signed [TEMP_W-1:0] TEMP_COLD =
        tvt_pkg::to_millic(tvt_pkg::FIRST_PT.celsius);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL1 = 9'b000000010,
        ST_DIV1 = 9'b000000100,
        ST_SRCH = 9'b000001000,
        ST_PREP = 9'b000010000,
        ST_MUL2 = 9'b000100000,
        ST_DIV2 = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t                              state_reg, state_next;
    logic [tvt_pkg::DIV_OHMS_W-1:0]      divider_reg, divider_next;
    logic [tvt_pkg::SUPPLY_W-1:0]        supply_reg, supply_next;
    logic [tvt_pkg::VOLT_W-1:0]          mv_reg, mv_next;
    logic [tvt_pkg::R_W-1:0]             r_reg, r_next;
    tvt_pkg::search_res_t                srch_reg, srch_next;
    logic signed [TEMP_W-1:0]            base_reg, base_next;
    logic                                neg_reg, neg_next;
    logic [tvt_pkg::DIV_D_W-1:0]         den_reg, den_next;
    logic signed [TEMP_W-1:0]            res_temp_reg, res_temp_next;
    logic                                res_fault_reg, res_fault_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [TEMP_W-1:0]            out_temp_reg;
    logic                                out_fault_reg;

    // Shared unit hookup
    logic                                mul_start, mul_done;
    logic [tvt_pkg::MUL_A_W-1:0]         mul_a;
    logic [tvt_pkg::MUL_B_W-1:0]         mul_b;
    logic [tvt_pkg::MUL_P_W-1:0]         mul_prod;
    logic                                div_start, div_done;
    logic [tvt_pkg::DIV_N_W-1:0]         div_n;
    logic [tvt_pkg::DIV_D_W-1:0]         div_d;
    logic [tvt_pkg::DIV_N_W-1:0]         div_quo;
    logic                                srch_start, srch_done;
    tvt_pkg::search_res_t                srch_res;

    // Interpolation setup terms
    logic                                in_take, bad_volt, out_load;
    logic [tvt_pkg::SUPPLY_W-1:0]        volt_ext, headroom;
    logic signed [TEMP_W-1:0]            base_v;
    logic signed [8:0]                   dc;
    logic signed [DCM_W-1:0]             dc_milli, dc_milli_n;
    logic signed [19:0]                  dr, dr_n, den, den_n;
    logic [17:0]                         dc_abs;
    logic [18:0]                         dr_abs, den_abs;
    logic signed [SUM_W-1:0]             q_ext, q_sgn, t_sum;

    tvt_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tvt_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .quo   (div_quo)
    );

    tvt_search #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_start),
        .r     (div_quo),
        .done  (srch_done),
        .res   (srch_res)
    );

    // Handshake terms
    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign in_take            = in_ch.valid && (state_reg == ST_IDLE);
    assign out_load           = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.temp_millic = out_temp_reg;
    assign out_ch.fault       = out_fault_reg;

    // Input range check and divider numerator term
    always_comb
    begin
        volt_ext = {1'b0, in_ch.voltage_mv};
        bad_volt = (in_ch.voltage_mv == '0) || (volt_ext > supply_reg);
        headroom = supply_reg - volt_ext;
    end

    // Interpolation setup from the picked entries
    always_comb
    begin
        base_v     = tvt_pkg::to_millic(srch_reg.lo.celsius);
        dc         = {srch_reg.hi.celsius[7], srch_reg.hi.celsius}
                   - {srch_reg.lo.celsius[7], srch_reg.lo.celsius};
        dc_milli   = DCM_W'(dc) * DC_MILLI;
        dc_milli_n = -dc_milli;
        dc_abs     = dc_milli[DCM_W-1] ? dc_milli_n[17:0] : dc_milli[17:0];
        dr         = $signed({1'b0, r_reg[18:0]}) - $signed({1'b0, srch_reg.lo.ohms});
        dr_n       = -dr;
        dr_abs     = dr[19] ? dr_n[18:0] : dr[18:0];
        den        = $signed({1'b0, srch_reg.hi.ohms}) - $signed({1'b0, srch_reg.lo.ohms});
        den_n      = -den;
        den_abs    = den[19] ? den_n[18:0] : den[18:0];
    end

    // Final sum with truncated quotient
    always_comb
    begin
        q_ext = $signed({2'b00, div_quo});
        q_sgn = neg_reg ? -q_ext : q_ext;
        t_sum = SUM_W'(base_reg) + q_sgn;
    end

    // Configuration writes
    always_comb
    begin
        divider_next = divider_reg;
        supply_next  = supply_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tvt_pkg::REG_DIVIDER: divider_next = cfg_data[tvt_pkg::DIV_OHMS_W-1:0];
                tvt_pkg::REG_SUPPLY:  supply_next  = cfg_data[tvt_pkg::SUPPLY_W-1:0];
                default:              divider_next = divider_reg;
            endcase
        end
    end

    // Conversion sequencer
    always_comb
    begin
        state_next     = state_reg;
        mv_next        = mv_reg;
        r_next         = r_reg;
        srch_next      = srch_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        den_next       = den_reg;
        res_temp_next  = res_temp_reg;
        res_fault_next = res_fault_reg;
        mul_start      = 1'b0;
        mul_a          = divider_reg;
        mul_b          = tvt_pkg::MUL_B_W'(headroom);
        div_start      = 1'b0;
        div_n          = mul_prod[tvt_pkg::DIV_N_W-1:0];
        div_d          = tvt_pkg::DIV_D_W'(mv_reg);
        srch_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    mv_next = in_ch.voltage_mv;
                    if (bad_volt)
                    begin
                        res_temp_next  = TEMP_COLD;
                        res_fault_next = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                // resistance = (supply - mv) * divider / mv
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    r_next     = div_quo;
                    srch_start = 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (srch_done)
                begin
                    srch_next  = srch_res;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (srch_reg.same || (den == '0))
                begin
                    res_temp_next  = base_v;
                    res_fault_next = 1'b0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    base_next  = base_v;
                    neg_next   = dc_milli[DCM_W-1] ^ dr[19] ^ den[19];
                    den_next   = den_abs;
                    mul_start  = 1'b1;
                    mul_a      = {2'b00, dc_abs};
                    mul_b      = {1'b0, dr_abs};
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_d      = den_reg;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Saturate to the 18-bit result range
                if (t_sum > SUM_W'(tvt_pkg::TEMP_MAX))
                begin
                    res_temp_next = tvt_pkg::TEMP_MAX;
                end
                else if (t_sum < SUM_W'(tvt_pkg::TEMP_MIN))
                begin
                    res_temp_next = tvt_pkg::TEMP_MIN;
                end
                else
                begin
                    res_temp_next = t_sum[TEMP_W-1:0];
                end
                res_fault_next = 1'b0;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            divider_reg   <= tvt_pkg::DIVIDER_RESET;
            supply_reg    <= tvt_pkg::SUPPLY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            divider_reg   <= divider_next;
            supply_reg    <= supply_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mv_reg        <= mv_next;
        r_reg         <= r_next;
        srch_reg      <= srch_next;
        base_reg      <= base_next;
        neg_reg       <= neg_next;
        den_reg       <= den_next;
        res_temp_reg  <= res_temp_next;
        res_fault_reg <= res_fault_next;
        if (out_load)
        begin
            out_temp_reg  <= res_temp_reg;
            out_fault_reg <= res_fault_reg;
        end
    end

    // Checks
    a_fault_cold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.fault |-> out_ch.temp_millic == TEMP_COLD)
        else $error("fault word without the coldest temperature");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL1) || (state_reg == ST_MUL2))
        else $error("multiplier finished outside a multiply state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV1) || (state_reg == ST_DIV2))
        else $error("divider finished outside a divide state");

    a_srch_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> state_reg == ST_SRCH)
        else $error("search finished outside the search state");

endmodule

FILE: rtl/tvt_serial_mul.sv
// Radix-4 shift-and-add multiplier: two multiplier bits per cycle.
// Depends on tvt_pkg for operand widths and step count.
module tvt_serial_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tvt_pkg::MUL_A_W-1:0]   a,
    input  logic [tvt_pkg::MUL_B_W-1:0]   b,
    output logic                          done,
    output logic [tvt_pkg::MUL_P_W-1:0]   prod
);

    localparam int HI_W = tvt_pkg::MUL_HI_W;
    localparam int B_W  = tvt_pkg::MUL_B_W;
    localparam int CW   = tvt_pkg::MUL_CNT_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [tvt_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic [HI_W-1:0]             a3_reg, a3_next;
    logic [HI_W+B_W-1:0]         p_reg, p_next;
    logic [HI_W-1:0]             addend;
    logic [HI_W-1:0]             hi_sum;

    // Partial product for the current radix-4 digit
    always_comb
    begin
        case (p_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = {2'b00, a_reg};
            2'd2:    addend = {1'b0, a_reg, 1'b0};
            default: addend = a3_reg;
        endcase
        hi_sum = p_reg[HI_W+B_W-1:B_W] + addend;
    end

    // Next state
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        a3_next   = a3_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(tvt_pkg::MUL_STEPS);
            a_next    = a;
            a3_next   = {2'b00, a} + {1'b0, a, 1'b0};
            p_next    = {{HI_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_next   = {2'b00, hi_sum, p_reg[B_W-1:2]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        a3_reg <= a3_next;
        p_reg  <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg[tvt_pkg::MUL_P_W-1:0];

endmodule

FILE: rtl/tvt_serial_div.sv
// Restoring divider: two quotient bits per cycle; divisor must be nonzero.
// Depends on tvt_pkg for operand widths and step count.
module tvt_serial_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tvt_pkg::DIV_N_W-1:0]   n,
    input  logic [tvt_pkg::DIV_D_W-1:0]   d,
    output logic                          done,
    output logic [tvt_pkg::DIV_N_W-1:0]   quo
);

    localparam int N_W = tvt_pkg::DIV_N_W;
    localparam int D_W = tvt_pkg::DIV_D_W;
    localparam int CW  = tvt_pkg::DIV_CNT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [N_W-1:0]    q_reg, q_next;
    logic [D_W:0]      t1, t2, s1, s2;
    logic              ge1, ge2;
    logic [D_W-1:0]    rem1, rem2;
    logic [N_W-1:0]    q1, q2;

    // Two restoring steps
    always_comb
    begin
        t1   = {rem_reg, q_reg[N_W-1]};
        ge1  = t1 >= {1'b0, d_reg};
        s1   = t1 - {1'b0, d_reg};
        rem1 = ge1 ? s1[D_W-1:0] : t1[D_W-1:0];
        q1   = {q_reg[N_W-2:0], ge1};
        t2   = {rem1, q1[N_W-1]};
        ge2  = t2 >= {1'b0, d_reg};
        s2   = t2 - {1'b0, d_reg};
        rem2 = ge2 ? s2[D_W-1:0] : t2[D_W-1:0];
        q2   = {q1[N_W-2:0], ge2};
    end

    // Next state
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(tvt_pkg::DIV_STEPS);
            d_next    = d;
            rem_next  = '0;
            q_next    = n;
        end
        else if (busy_reg)
        begin
            rem_next = rem2;
            q_next   = q2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/tvt_search.sv
// Binary search sequencer over the fixed curve, one probe step per cycle.
// Depends on tvt_pkg for the curve contents and the result struct.
module tvt_search #(
    parameter int TABLE_ENTRIES = 49
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tvt_pkg::R_W-1:0]     r,
    output logic                        done,
    output tvt_pkg::search_res_t        res
);

    localparam int N     = (TABLE_ENTRIES > tvt_pkg::CURVE_LEN) ? tvt_pkg::CURVE_LEN
                                                               : TABLE_ENTRIES;
    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(N - 1);
    localparam logic [IDX_W-1:0] LIMIT = IDX_W'(N);
    localparam int R_W = tvt_pkg::R_W;
    localparam int PAD = R_W - tvt_pkg::OHMS_W;

    typedef enum logic [2:0] {
        SR_IDLE  = 3'b001,
        SR_CHECK = 3'b010,
        SR_LOOP  = 3'b100
    } sr_state_t;

    sr_state_t               state_reg, state_next;
    logic                    done_reg, done_next;
    logic [R_W-1:0]          r_reg, r_next;
    logic [IDX_W-1:0]        a_reg, a_next;
    logic [IDX_W-1:0]        b_reg, b_next;
    tvt_pkg::search_res_t    res_reg, res_next;

    logic [IDX_W-1:0]        m, a1;
    logic                    hi_same;
    tvt_pkg::curve_pt_t      p_first, p_last, p_m, p_a1, p_b, p_bm1;

    // Entry read with the index held inside the table
    function automatic tvt_pkg::curve_pt_t pick(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] k;
        k = (idx > LAST) ? LAST : idx;
        return tvt_pkg::curve_entry(8'(k));
    endfunction

    function automatic logic r_ge(input logic [R_W-1:0] rv, input logic [tvt_pkg::OHMS_W-1:0] o);
        return rv >= {{PAD{1'b0}}, o};
    endfunction

    // Probe addresses and table reads
    always_comb
    begin
        m       = a_reg + ((b_reg - a_reg) >> 1);
        a1      = m + IDX_W'(1);
        p_first = pick('0);
        p_last  = pick(LAST);
        p_m     = pick(m);
        p_a1    = pick(a1);
        p_b     = pick(b_reg);
        p_bm1   = pick(b_reg - IDX_W'(1));
        hi_same = (r_reg == {{PAD{1'b0}}, p_b.ohms}) || (b_reg == '0);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        case (state_reg)
            SR_IDLE:
            begin
                if (start)
                begin
                    r_next     = r;
                    state_next = SR_CHECK;
                end
            end
            SR_CHECK:
            begin
                // Clamp at either end of the curve
                if (r_ge(r_reg, p_first.ohms))
                begin
                    res_next   = '{1'b1, p_first, p_first};
                    done_next  = 1'b1;
                    state_next = SR_IDLE;
                end
                else if (!r_ge(r_reg, p_last.ohms) || (r_reg == {{PAD{1'b0}}, p_last.ohms}))
                begin
                    res_next   = '{1'b1, p_last, p_last};
                    done_next  = 1'b1;
                    state_next = SR_IDLE;
                end
                else
                begin
                    a_next     = '0;
                    b_next     = LIMIT;
                    state_next = SR_LOOP;
                end
            end
            SR_LOOP:
            begin
                if (a_reg < b_reg)
                begin
                    if (r_ge(r_reg, p_m.ohms))
                    begin
                        b_next = m;
                    end
                    else
                    begin
                        a_next = a1;
                        if (r_ge(r_reg, p_a1.ohms))
                        begin
                            b_next = a1;
                        end
                    end
                end
                else
                begin
                    res_next.same = hi_same;
                    res_next.lo   = p_b;
                    res_next.hi   = hi_same ? p_b : p_bm1;
                    done_next     = 1'b1;
                    state_next    = SR_IDLE;
                end
            end
            default:
            begin
                state_next = SR_IDLE;
            end
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SR_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
